/* sv/adr_pkg.sv */
// Package for the anti-aliased disc rasterizer.
// Holds field widths, constants, the disc descriptor and the sequencer states.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package adr_pkg;

  localparam int MaxRadius = 3;
  localparam int CoordW    = 12;
  localparam int FixW      = 16;
  localparam int RadW      = 6;
  localparam int LevelW    = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 12;
  localparam int SqW       = 48;
  localparam int RootW     = 24;

  localparam logic [CfgIdxW-1:0]  RegScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0]  RegScreenHeight = CfgIdxW'(1);
  localparam logic [CoordW-1:0]   WidthReset      = CoordW'(640);
  localparam logic [CoordW-1:0]   HeightReset     = CoordW'(480);
  localparam logic [RadW-1:0]     RadMax          = RadW'(MaxRadius * 16);
  localparam logic [17:0]         LevelScale      = 18'd260100;
  localparam logic [LevelW-1:0]   LevelFull       = 8'd255;

  typedef struct packed {
    logic              is_small;
    logic [CoordW-1:0] xfl;
    logic [CoordW-1:0] yfl;
    logic [3:0]        xf;
    logic [3:0]        yf;
    logic [RadW-1:0]   rad;
    logic [1:0]        rc;
    logic [10:0]       rin2;
    logic [11:0]       rsq;
  } disc_t;

  typedef struct packed {
    logic           start;
    logic [SqW-1:0] operand;
  } sq_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sq_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SM_R2,
    ST_SM_A,
    ST_SM_B,
    ST_SM_PIX,
    ST_LG_PIX,
    ST_MUL,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_EMIT,
    ST_FLUSH
  } back_state_e;

endpackage

`default_nettype wire

/* sv/adr_ifs.sv */
// Handshake interfaces of the disc rasterizer: disc requests, pixel results
// and configuration writes. Depends on adr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface adr_disc_if import adr_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [FixW-1:0] center_x;
  logic [FixW-1:0] center_y;
  logic [RadW-1:0] disc_radius;
  modport source (output valid, center_x, center_y, disc_radius, input ready);
  modport sink   (input valid, center_x, center_y, disc_radius, output ready);
endinterface

interface adr_pix_if import adr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] pixel_x;
  logic [CoordW-1:0] pixel_y;
  logic [LevelW-1:0] pixel_level;
  logic              final_pixel;
  modport source (output valid, pixel_x, pixel_y, pixel_level, final_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_level, final_pixel, output ready);
endinterface

interface adr_cfg_if import adr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/adr_front.sv */
// Front end: takes a disc request, clamps the radius and derives the scan
// parameters pushed into the descriptor queue. Depends on adr_pkg, adr_ifs.
`timescale 1ns / 1ps
`default_nettype none

module adr_front import adr_pkg::*; (
  adr_disc_if.sink    disc_i,
  output logic        push_valid_o,
  output disc_t       push_data_o,
  input  logic        push_ready_i
);

  logic [RadW-1:0] rad;
  logic [6:0]      rad_up;
  logic [RadW-1:0] rin;

  always_comb begin
    rad    = (disc_i.disc_radius > RadMax) ? RadMax : disc_i.disc_radius;
    rad_up = {1'b0, rad} + 7'd15;
    rin    = rad - RadW'(16);
    push_data_o.is_small = (rad < RadW'(16));
    push_data_o.xfl      = disc_i.center_x[FixW-1:4];
    push_data_o.yfl      = disc_i.center_y[FixW-1:4];
    push_data_o.xf       = disc_i.center_x[3:0];
    push_data_o.yf       = disc_i.center_y[3:0];
    push_data_o.rad      = rad;
    push_data_o.rc       = rad_up[5:4];
    push_data_o.rin2     = 11'(rin) * 11'(rin);
    push_data_o.rsq      = 12'(rad) * 12'(rad);
  end

  assign push_valid_o = disc_i.valid;
  assign disc_i.ready = push_ready_i;

endmodule

`default_nettype wire

/* sv/adr_queue.sv */
// Two-entry descriptor queue between the front end and the pixel sequencer.
// Depends on adr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adr_queue import adr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  disc_t data_i,
  output logic  ready_o,
  output logic  valid_o,
  output disc_t data_o,
  input  logic  pop_i
);

  disc_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/adr_sqrt.sv */
// Iterative integer square root, two result bits per cycle.
// Depends on adr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module adr_sqrt import adr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  sq_req_t req_i,
  output sq_rsp_t rsp_o
);

  logic [SqW-1:0] v_q, v_d;
  logic [SqW-1:0] res_q, res_d;
  logic [SqW-1:0] bit_q, bit_d;
  logic           busy_q, done_q;

  always_comb begin
    v_d   = v_q;
    res_d = res_q;
    bit_d = bit_q;
    for (int s = 0; s < 2; s++) begin
      if (v_d >= res_d + bit_d) begin
        v_d   = v_d - (res_d + bit_d);
        res_d = (res_d >> 1) + bit_d;
      end else begin
        res_d = res_d >> 1;
      end
      bit_d = bit_d >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !req_i.start && (bit_d == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_d == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      v_q   <= req_i.operand;
      res_q <= '0;
      bit_q <= SqW'(1) << (SqW - 2);
    end else if (busy_q) begin
      v_q   <= v_d;
      res_q <= res_d;
      bit_q <= bit_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[RootW-1:0];

endmodule

`default_nettype wire

/* sv/adr_back.sv */
// Pixel sequencer: walks the candidate pixels of one disc, computes the
// brightness with the shared square-root unit and drives the pixel channel.
// Depends on adr_pkg, adr_ifs and adr_sqrt (through the top level).
`timescale 1ns / 1ps
`default_nettype none

module adr_back import adr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  disc_t             q_data_i,
  output logic              q_pop_o,
  input  logic [CoordW-1:0] width_i,
  input  logic [CoordW-1:0] height_i,
  output sq_req_t           sq_req_o,
  input  sq_rsp_t           sq_rsp_i,
  adr_pix_if.source         pix_o
);

  back_state_e state_q, state_d;
  disc_t       d_q;
  logic [1:0]  k_q;
  logic signed [2:0] i_q, j_q;
  logic [7:0]  r2_q;
  logic [11:0] a_q;
  logic [15:0] rr_q;
  logic [23:0] aa_q, b_q;
  logic [28:0] m_q;
  logic [SqW-1:0] prod_q;
  logic        dist_q;
  logic [LevelW-1:0] lvl_q;
  logic        pend_vld_q;
  logic [CoordW-1:0] pend_x_q, pend_y_q;
  logic [LevelW-1:0] pend_lvl_q;
  logic        out_vld_q;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic [LevelW-1:0] out_lvl_q;
  logic        out_fin_q;

  logic [12:0] sx, sy;
  logic        s_on;
  logic signed [13:0] lx, ly;
  logic        l_on;
  logic signed [7:0] dx, dy;
  logic [15:0] dxsq, dysq;
  logic [13:0] d2;
  logic [23:0] msel;
  logic [4:0]  wt;
  logic [28:0] m_new;
  logic [13:0] depth;
  logic [24:0] rnd;
  logic [17:0] lvl_raw;
  logic [LevelW-1:0] lvl_new;
  logic signed [2:0] rcs, istart;
  logic        last;
  logic [CoordW-1:0] cur_x, cur_y;
  logic        out_free;
  logic        do_adv, pend_load, push_out, push_fin, sq_start;

  always_comb begin
    sx   = {1'b0, d_q.xfl} + 13'(k_q[0]);
    sy   = {1'b0, d_q.yfl} + 13'(k_q[1]);
    s_on = (sx < {1'b0, width_i}) && (sy < {1'b0, height_i});
    lx   = signed'({2'b00, d_q.xfl}) + 14'(i_q);
    ly   = signed'({2'b00, d_q.yfl}) + 14'(j_q);
    l_on = !lx[13] && !ly[13] && (lx[12:0] < {1'b0, width_i})
           && (ly[12:0] < {1'b0, height_i});
    dx   = 8'((8'(i_q) <<< 4) - {4'b0000, d_q.xf});
    dy   = 8'((8'(j_q) <<< 4) - {4'b0000, d_q.yf});
    dxsq = 16'(dx) * 16'(dx);
    dysq = 16'(dy) * 16'(dy);
    d2   = 14'(dxsq) + 14'(dysq);
    msel = k_q[0] ? b_q : aa_q;
    wt   = k_q[1] ? {1'b0, d_q.yf} : 5'd16 - {1'b0, d_q.yf};
    m_new = 29'(msel) * 29'(wt);
    depth = {d_q.rad, 8'h00} - sq_rsp_i.root[13:0];
    rnd  = d_q.is_small ? ({1'b0, sq_rsp_i.root} + 25'd16384)
                        : ({1'b0, sq_rsp_i.root} + 25'd64);
    lvl_raw = d_q.is_small ? 18'(rnd >> 15) : 18'(rnd >> 7);
    lvl_new = (lvl_raw > 18'(LevelFull)) ? LevelFull : lvl_raw[LevelW-1:0];
    rcs    = signed'({1'b0, d_q.rc});
    istart = ~signed'({1'b0, q_data_i.rc});
    last   = d_q.is_small ? (k_q == 2'd3) : ((i_q == rcs) && (j_q == rcs));
    cur_x  = d_q.is_small ? sx[CoordW-1:0] : lx[CoordW-1:0];
    cur_y  = d_q.is_small ? sy[CoordW-1:0] : ly[CoordW-1:0];
    out_free = !out_vld_q || pix_o.ready;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = q_data_i.is_small ? ST_SM_R2 : ST_LG_PIX;
        end
      end
      ST_SM_R2: state_d = ST_SM_A;
      ST_SM_A:  state_d = ST_SM_B;
      ST_SM_B:  state_d = ST_SM_PIX;
      ST_SM_PIX: begin
        if (s_on) begin
          state_d = ST_MUL;
        end else if (last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_LG_PIX: begin
        if (l_on && (d2 <= 14'(d_q.rin2))) begin
          state_d = ST_EMIT;
        end else if (l_on && (d2 < 14'(d_q.rsq))) begin
          state_d = ST_SQ_GO;
        end else if (last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_MUL:   state_d = ST_SQ_GO;
      ST_SQ_GO: state_d = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (sq_rsp_i.done) begin
          state_d = dist_q ? ST_MUL : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!pend_vld_q || out_free) begin
          if (last) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = d_q.is_small ? ST_SM_PIX : ST_LG_PIX;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    do_adv    = 1'b0;
    pend_load = 1'b0;
    push_out  = 1'b0;
    push_fin  = 1'b0;
    sq_start  = 1'b0;
    unique case (state_q)
      ST_IDLE:   q_pop_o = q_valid_i;
      ST_SM_PIX: do_adv = !s_on;
      ST_LG_PIX: do_adv = !(l_on && (d2 < 14'(d_q.rsq)));
      ST_SQ_GO:  sq_start = 1'b1;
      ST_EMIT: begin
        if (!pend_vld_q || out_free) begin
          do_adv    = 1'b1;
          pend_load = 1'b1;
          push_out  = pend_vld_q;
        end
      end
      ST_FLUSH: begin
        push_out = pend_vld_q && out_free;
        push_fin = 1'b1;
      end
      default: ;
    endcase
  end

  assign sq_req_o.start   = sq_start;
  assign sq_req_o.operand = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pend_load) begin
        pend_vld_q <= 1'b1;
      end else if (push_out) begin
        pend_vld_q <= 1'b0;
      end
      if (push_out) begin
        out_vld_q <= 1'b1;
      end else if (pix_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      d_q <= q_data_i;
      k_q <= 2'd0;
      i_q <= istart;
      j_q <= istart;
    end else if (do_adv) begin
      if (d_q.is_small) begin
        k_q <= k_q + 2'd1;
      end else if (i_q == rcs) begin
        i_q <= ~rcs;
        j_q <= j_q + 3'sd1;
      end else begin
        i_q <= i_q + 3'sd1;
      end
    end
    if (state_q == ST_SM_R2) begin
      r2_q <= 8'(d_q.rad[3:0]) * 8'(d_q.rad[3:0]);
    end
    if (state_q == ST_SM_A) begin
      a_q  <= 12'(r2_q) * 12'(5'd16 - {1'b0, d_q.xf});
      rr_q <= 16'(r2_q) * 16'(r2_q);
    end
    if (state_q == ST_SM_B) begin
      aa_q <= 24'(a_q) * 24'(a_q);
      b_q  <= 24'({rr_q, 4'h0}) * 24'(d_q.xf);
    end
    if (state_q == ST_SM_PIX) begin
      m_q    <= m_new;
      dist_q <= 1'b0;
    end
    if (state_q == ST_LG_PIX) begin
      prod_q <= SqW'({d2, 16'h0000});
      dist_q <= 1'b1;
      lvl_q  <= LevelFull;
    end
    if (state_q == ST_MUL) begin
      prod_q <= SqW'(m_q) * SqW'(LevelScale);
    end
    if ((state_q == ST_SQ_WAIT) && sq_rsp_i.done) begin
      if (dist_q) begin
        m_q    <= 29'(depth);
        dist_q <= 1'b0;
      end else begin
        lvl_q <= lvl_new;
      end
    end
    if (pend_load) begin
      pend_x_q   <= cur_x;
      pend_y_q   <= cur_y;
      pend_lvl_q <= lvl_q;
    end
    if (push_out) begin
      out_x_q   <= pend_x_q;
      out_y_q   <= pend_y_q;
      out_lvl_q <= pend_lvl_q;
      out_fin_q <= push_fin;
    end
  end

  assign pix_o.valid       = out_vld_q;
  assign pix_o.pixel_x     = out_x_q;
  assign pix_o.pixel_y     = out_y_q;
  assign pix_o.pixel_level = out_lvl_q;
  assign pix_o.final_pixel = out_fin_q;

endmodule

`default_nettype wire

/* sv/antialiased_disc_rasterizer.sv */
// Top level of the anti-aliased disc rasterizer: configuration registers,
// front end, descriptor queue, pixel sequencer and square-root unit.
// Depends on adr_pkg, adr_ifs, adr_front, adr_queue, adr_sqrt, adr_back.
`timescale 1ns / 1ps
`default_nettype none

// Each disc request yields up to 64 pixel results in raster order, the last
// one flagged by final_pixel. The front end takes a new disc every cycle
// into a two-entry queue while the queue has room; the sequencer handles
// one disc at a time. A disc with radius below one pixel first computes its
// setup products, then runs the shared square-root unit once per on-screen
// pixel. A larger disc visits each candidate in its scan window (at most
// 64), emits each full pixel directly and runs the shared square-root unit
// twice per rim pixel; even the largest radius has only about two dozen rim
// pixels. Output stalls hold the sequencer back. A finished pixel waits in
// an output register while the next one is computed.
module antialiased_disc_rasterizer import adr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  adr_cfg_if.sink    cfg_i,
  adr_disc_if.sink   disc_i,
  adr_pix_if.source  pix_o
);

  logic [CoordW-1:0] width_q, height_q;
  logic    push_valid, push_ready;
  disc_t   push_data;
  logic    q_valid, q_pop;
  disc_t   q_data;
  sq_req_t sq_req;
  sq_rsp_t sq_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegScreenWidth) begin
        width_q <= cfg_i.data;
      end
      if (cfg_i.index == RegScreenHeight) begin
        height_q <= cfg_i.data;
      end
    end
  end

  adr_front u_front (
    .disc_i       (disc_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  adr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_valid),
    .data_i  (push_data),
    .ready_o (push_ready),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  adr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  adr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .width_i   (width_q),
    .height_i  (height_q),
    .sq_req_o  (sq_req),
    .sq_rsp_i  (sq_rsp),
    .pix_o     (pix_o)
  );

endmodule

`default_nettype wire

/* sv/adr_checker.sv */
// Port-level checker for the disc rasterizer and its bind to the top level.
// Depends on adr_pkg and antialiased_disc_rasterizer.
`timescale 1ns / 1ps
`default_nettype none

module adr_checker import adr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_i,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                pix_valid_i,
  input logic                pix_ready_i,
  input logic [CoordW-1:0]   pixel_x_i,
  input logic [CoordW-1:0]   pixel_y_i,
  input logic [LevelW-1:0]   pixel_level_i,
  input logic                final_pixel_i
);

  logic [CoordW-1:0] w_q, h_q, px_q, py_q;
  logic              prev_q;
  logic              pix_acc;

  assign pix_acc = pix_valid_i && pix_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= WidthReset;
      h_q    <= HeightReset;
      prev_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_i && (cfg_index_i == RegScreenWidth)) begin
        w_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_ready_i && (cfg_index_i == RegScreenHeight)) begin
        h_q <= cfg_data_i;
      end
      if (pix_acc) begin
        prev_q <= !final_pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
  end

  a_pix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pixel_x_i)
      && $stable(pixel_y_i) && $stable(pixel_level_i) && $stable(final_pixel_i))
    else $error("pixel result changed while stalled");

  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc |-> (pixel_x_i < w_q) && (pixel_y_i < h_q))
    else $error("pixel outside the visible screen");

  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc && prev_q |-> (pixel_y_i > py_q)
      || ((pixel_y_i == py_q) && (pixel_x_i > px_q)))
    else $error("pixels of one disc out of raster order");

endmodule

bind antialiased_disc_rasterizer adr_checker u_adr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_i.valid),
  .cfg_ready_i   (cfg_i.ready),
  .cfg_index_i   (cfg_i.index),
  .cfg_data_i    (cfg_i.data),
  .pix_valid_i   (pix_o.valid),
  .pix_ready_i   (pix_o.ready),
  .pixel_x_i     (pix_o.pixel_x),
  .pixel_y_i     (pix_o.pixel_y),
  .pixel_level_i (pix_o.pixel_level),
  .final_pixel_i (pix_o.final_pixel)
);

`default_nettype wire
